[rtl/tpt_pkg.sv]
// Shared types and fixed field widths for the paging translator.
// Used by the TLB and the top level; depends on nothing else.
package tpt_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned PHYS_W = 15;
  localparam int unsigned EVP_W  = 8;

  typedef struct packed {
    logic fill_rr;
    logic fill_fault;
    logic ev_valid;
  } tlb_cmd_t;

endpackage

[rtl/tpt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; contents are undefined until written.
module tpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/tpt_tlb.sv]
// Fully associative TLB with parallel tag match and slot placement.
// Depends on tpt_pkg for the fill command.
module tpt_tlb #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned TAG_W       = 8,
  parameter int unsigned FRAME_W     = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TAG_W-1:0]  look_tag_i,
  output logic              hit_o,
  output logic [FRAME_W-1:0] frame_o,
  input  logic [TAG_W-1:0]  ev_tag_i,
  input  tpt_pkg::tlb_cmd_t cmd_i,
  input  logic [TAG_W-1:0]  wr_tag_i,
  input  logic [FRAME_W-1:0] wr_frame_i
);

  localparam int unsigned IW = $clog2(TLB_ENTRIES);

  logic [TLB_ENTRIES-1:0] valid_q;
  logic [TAG_W-1:0]       tag_q   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     frame_q [TLB_ENTRIES];
  logic [IW-1:0]          ptr_q, ptr_d;

  logic          hit, ev_found, empty_found, use_rr, wr_en;
  logic [IW-1:0] hit_idx, ev_idx, empty_idx, wr_idx;

  always_comb begin
    hit         = 1'b0;
    ev_found    = 1'b0;
    empty_found = 1'b0;
    hit_idx     = '0;
    ev_idx      = '0;
    empty_idx   = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == look_tag_i) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
      if (valid_q[i] && tag_q[i] == ev_tag_i) begin
        ev_found = 1'b1;
        ev_idx   = IW'(i);
      end
      if (!valid_q[i]) begin
        empty_found = 1'b1;
        empty_idx   = IW'(i);
      end
    end
  end

  assign hit_o   = hit;
  assign frame_o = frame_q[hit_idx];

  always_comb begin
    use_rr = cmd_i.fill_rr ||
             (cmd_i.fill_fault && (cmd_i.ev_valid ? !ev_found : !empty_found));
    wr_en  = cmd_i.fill_rr || cmd_i.fill_fault;
    if (use_rr) begin
      wr_idx = ptr_q;
    end else if (cmd_i.ev_valid) begin
      wr_idx = ev_idx;
    end else begin
      wr_idx = empty_idx;
    end
    ptr_d = ptr_q;
    if (wr_en && use_rr) begin
      ptr_d = (ptr_q == IW'(TLB_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
    end else begin
      ptr_q <= ptr_d;
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_q[wr_idx]   <= wr_tag_i;
      frame_q[wr_idx] <= wr_frame_i;
    end
  end

endmodule

[rtl/tlb_paging_translator.sv]
// Paging translator top level: TLB lookup, page map walk and FIFO frame replacement.
// Depends on tpt_pkg, tpt_ram and tpt_tlb.
//
// Channel   Dir   Ports                                                           Strobe
// request   in    logical_address_i                                               start_i & !busy_o
// result    out   phys_addr_o tlb_hit_o page_fault_o evicted_valid_o evicted_page_o  done_o
//
// A request passes S_MOD, which reduces the page number, then S_LOOK for the TLB lookup; a
// TLB miss adds S_PMRD for the registered page map read, where a page map hit and a page
// fault both report. A fault then adds S_FILL for a second write on the page map's single
// write port. After reset the page map is swept invalid, one entry at a time, with busy_o
// high. A result is shown for exactly one cycle; the receiver cannot stall. After a hit the
// next request may be accepted at the edge that ends it, after a fault once S_FILL is done.
module tlb_paging_translator #(
  parameter int unsigned OFFSET_WIDTH = 8,
  parameter int unsigned TLB_ENTRIES  = 16,
  parameter int unsigned PAGE_COUNT   = 256,
  parameter int unsigned FRAME_COUNT  = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [tpt_pkg::ADDR_W-1:0]  logical_address_i,
  output logic                        done_o,
  output logic [tpt_pkg::PHYS_W-1:0]  phys_addr_o,
  output logic                        tlb_hit_o,
  output logic                        page_fault_o,
  output logic                        evicted_valid_o,
  output logic [tpt_pkg::EVP_W-1:0]   evicted_page_o
);

  localparam int unsigned VPN_W   = tpt_pkg::ADDR_W - OFFSET_WIDTH;
  localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  localparam int unsigned DIV_S   = VPN_W + PAGE_W;
  localparam int unsigned PROD_W  = DIV_S + VPN_W;
  localparam int unsigned REM_W   = VPN_W + PAGE_W;
  localparam longint unsigned RECIP =
    ((64'd1 << DIV_S) + PAGE_COUNT - 1) / PAGE_COUNT;
  localparam logic [REM_W-1:0] PC_L = REM_W'(PAGE_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_LOOK  = 3'd3;
  localparam logic [2:0] S_PMRD  = 3'd4;
  localparam logic [2:0] S_FILL  = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [PAGE_W-1:0]       clr_cnt_q, clr_cnt_d;
  logic [FRAME_W-1:0]      frame_ptr_q, frame_ptr_d;
  logic                    wrapped_q, wrapped_d;
  logic                    done_q, done_d;

  logic [VPN_W-1:0]        vpn_q;
  logic [OFFSET_WIDTH-1:0] offset_q;
  logic [PROD_W-1:0]       prod_q;
  logic [PAGE_W-1:0]       page_q, page_d;
  logic [FRAME_W-1:0]      victim_q;

  logic [tpt_pkg::PHYS_W-1:0] phys_q, phys_d;
  logic                       hit_q, hit_d, fault_q, fault_d, evv_q, evv_d;
  logic [tpt_pkg::EVP_W-1:0]  evp_q, evp_d;

  logic [VPN_W-1:0]  quot;
  logic [REM_W-1:0]  rem_w;

  logic               pm_we;
  logic [PAGE_W-1:0]  pm_waddr;
  logic [FRAME_W:0]   pm_wdata, pm_rdata;
  logic               fo_we;
  logic [PAGE_W-1:0]  fo_rdata;

  logic               tlb_hit;
  logic [FRAME_W-1:0] tlb_frame;
  tpt_pkg::tlb_cmd_t  tlb_cmd;
  logic [FRAME_W-1:0] fill_frame;

  logic [FRAME_W-1:0] frame_sel;
  logic [tpt_pkg::PHYS_W+FRAME_W+OFFSET_WIDTH-1:0] phys_full;
  logic [tpt_pkg::EVP_W+PAGE_W-1:0]                evp_full;
  logic accept;

  assign accept = start_i && (state_q == S_IDLE);
  assign busy_o = (state_q != S_IDLE);

  assign quot  = prod_q[DIV_S +: VPN_W];
  assign rem_w = {PAGE_W'(0), vpn_q} - REM_W'(quot) * PC_L;
  assign page_d = rem_w[PAGE_W-1:0];

  tpt_ram #(
    .WIDTH (FRAME_W + 1),
    .DEPTH (PAGE_COUNT)
  ) u_page_map (
    .clk_i   (clk_i),
    .we_i    (pm_we),
    .waddr_i (pm_waddr),
    .wdata_i (pm_wdata),
    .raddr_i (page_q),
    .rdata_o (pm_rdata)
  );

  tpt_ram #(
    .WIDTH (PAGE_W),
    .DEPTH (FRAME_COUNT)
  ) u_frame_owner (
    .clk_i   (clk_i),
    .we_i    (fo_we),
    .waddr_i (frame_ptr_q),
    .wdata_i (page_q),
    .raddr_i (frame_ptr_q),
    .rdata_o (fo_rdata)
  );

  tpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .TAG_W       (PAGE_W),
    .FRAME_W     (FRAME_W)
  ) u_tlb (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .look_tag_i (page_q),
    .hit_o      (tlb_hit),
    .frame_o    (tlb_frame),
    .ev_tag_i   (fo_rdata),
    .cmd_i      (tlb_cmd),
    .wr_tag_i   (page_q),
    .wr_frame_i (fill_frame)
  );

  assign fill_frame = pm_rdata[FRAME_W] ? pm_rdata[FRAME_W-1:0] : frame_ptr_q;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    frame_ptr_d = frame_ptr_q;
    wrapped_d   = wrapped_q;
    done_d      = 1'b0;
    pm_we       = 1'b0;
    pm_waddr    = page_q;
    pm_wdata    = '0;
    fo_we       = 1'b0;
    tlb_cmd     = '0;
    frame_sel   = tlb_frame;
    hit_d       = 1'b0;
    fault_d     = 1'b0;
    evv_d       = 1'b0;
    evp_d       = '0;

    unique case (state_q)
      S_CLEAR: begin
        pm_we     = 1'b1;
        pm_waddr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == PAGE_W'(PAGE_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        state_d = S_LOOK;
      end
      S_LOOK: begin
        if (tlb_hit) begin
          done_d  = 1'b1;
          hit_d   = 1'b1;
          state_d = S_IDLE;
        end else begin
          state_d = S_PMRD;
        end
      end
      S_PMRD: begin
        done_d = 1'b1;
        if (pm_rdata[FRAME_W]) begin
          frame_sel       = pm_rdata[FRAME_W-1:0];
          tlb_cmd.fill_rr = 1'b1;
          state_d         = S_IDLE;
        end else begin
          frame_sel          = frame_ptr_q;
          fault_d            = 1'b1;
          evv_d              = wrapped_q;
          evp_d              = wrapped_q ? evp_full[tpt_pkg::EVP_W-1:0] : '0;
          tlb_cmd.fill_fault = 1'b1;
          tlb_cmd.ev_valid   = wrapped_q;
          pm_we              = wrapped_q;
          pm_waddr           = fo_rdata;
          fo_we              = 1'b1;
          if (frame_ptr_q == FRAME_W'(FRAME_COUNT - 1)) begin
            frame_ptr_d = '0;
            wrapped_d   = 1'b1;
          end else begin
            frame_ptr_d = frame_ptr_q + 1'b1;
          end
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        pm_we    = 1'b1;
        pm_waddr = page_q;
        pm_wdata = {1'b1, victim_q};
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign phys_full = {tpt_pkg::PHYS_W'(0), frame_sel, offset_q};
  assign phys_d    = phys_full[tpt_pkg::PHYS_W-1:0];
  assign evp_full  = {tpt_pkg::EVP_W'(0), fo_rdata};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      frame_ptr_q <= '0;
      wrapped_q   <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      frame_ptr_q <= frame_ptr_d;
      wrapped_q   <= wrapped_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vpn_q    <= logical_address_i[tpt_pkg::ADDR_W-1:OFFSET_WIDTH];
      offset_q <= logical_address_i[OFFSET_WIDTH-1:0];
      prod_q   <= PROD_W'(logical_address_i[tpt_pkg::ADDR_W-1:OFFSET_WIDTH]) *
                  PROD_W'(RECIP);
    end
    if (state_q == S_MOD) begin
      page_q <= page_d;
    end
    if (state_q == S_PMRD) begin
      victim_q <= frame_ptr_q;
    end
    if (done_d) begin
      phys_q  <= phys_d;
      hit_q   <= hit_d;
      fault_q <= fault_d;
      evv_q   <= evv_d;
      evp_q   <= evp_d;
    end
  end

  assign done_o          = done_q;
  assign phys_addr_o     = phys_q;
  assign tlb_hit_o       = hit_q;
  assign page_fault_o    = fault_q;
  assign evicted_valid_o = evv_q;
  assign evicted_page_o  = evp_q;

`ifndef SYNTHESIS
  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_LOOK || $past(state_q) == S_PMRD))
    else $error("Result strobe without a finished lookup.");

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && tlb_hit_o |-> !page_fault_o && !evicted_valid_o)
    else $error("TLB hit reported together with a fault.");

  a_evict_needs_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_valid_o |-> page_fault_o)
    else $error("Eviction reported without a page fault.");

  a_accept_no_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> !done_o && busy_o)
    else $error("Request accepted but block not working on it.");
`endif

endmodule
